[sv/windowed_random_subset_picker_top_macros.svh]
// Assertion macros for the windowed random subset picker
`ifndef WINDOWED_RANDOM_SUBSET_PICKER_TOP_MACROS_SVH
`define WINDOWED_RANDOM_SUBSET_PICKER_TOP_MACROS_SVH
// implication checked every clock outside reset
`define WRSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define WRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/wrsp_pkg.sv]
// Shared types and constants for the windowed random subset picker
package wrsp_pkg;
    localparam int MAX_POSITIONS_DEF = 4096;
    localparam int CFG_W  = 13;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_RAND  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_MORE   = 2'd0,
        ST_DONE   = 2'd1,
        ST_IGNORE = 2'd2,
        ST_RSVD   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_POST = 2'd0,
        REG_PRE  = 2'd1,
        REG_PICK = 2'd2,
        REG_HALF = 2'd3
    } t_reg;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_div_rsp;
endpackage

[sv/wrsp_divider.sv]
// Restoring remainder unit, one quotient bit per cycle
module wrsp_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrsp_pkg::t_div_req i_req,
    output wrsp_pkg::t_div_rsp o_rsp
);
    import wrsp_pkg::*;

    logic [47:0] r_dvd;
    logic [32:0] r_rem;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_shift;

    assign n_shift = {r_rem[31:0], r_dvd[47]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= 6'd48;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[46:0], 1'b0};
                if (n_shift >= {1'b0, r_dvs}) begin
                    r_rem <= n_shift - {1'b0, r_dvs};
                end else begin
                    r_rem <= n_shift;
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[31:0];
endmodule

[sv/windowed_random_subset_picker_top.sv]
// Top level: sequencer, candidate memory and configuration registers
// Begin row: a 48-step modulo (skipped when the ring is empty), then one compare per pre index.
// Random word: a bit-serial remainder, then the memory swap with its two writes.
// Read: through the registered memory port (RDA, RDB, RDOUT); ignored words answer from idle.
// Reset is synchronous active low: configuration registers return to defaults, phase idle,
// candidate memory left unwritten. Results are strobed one cycle and cannot be stalled.
module windowed_random_subset_picker_top #(
    parameter int MAX_POSITIONS = wrsp_pkg::MAX_POSITIONS_DEF,
    parameter int IW = $clog2(MAX_POSITIONS),
    parameter int CW = $clog2(MAX_POSITIONS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [wrsp_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [1:0]                i_kind,
    input  logic [11:0]               i_post_index,
    input  logic [31:0]               i_random_word,
    output logic                      o_valid,
    output logic [12:0]               o_candidate_count,
    output logic [11:0]               o_pre_index,
    output logic                      o_last,
    output logic [1:0]                o_status
);
    import wrsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_AMOD, S_SCAN, S_SWDIV, S_SWRD, S_SWWAIT, S_SWWR, S_SWPUT,
        S_RDA, S_RDB, S_RDOUT
    } t_state;

    localparam int PH_IDLE = 0;

    logic [CFG_W-1:0] r_post, r_pre, r_pick, r_half;
    logic [IW-1:0]    r_mem [MAX_POSITIONS];
    logic [IW-1:0]    r_rd;
    logic [CW-1:0]    r_found, r_readp;
    logic [IW-1:0]    r_swp, r_ridx;
    logic [1:0]       r_phase;
    t_state           r_state;
    logic [24:0]      r_m, r_a, r_b;
    logic [25:0]      r_lim;
    logic [12:0]      r_npost, r_npre, r_j;
    logic [IW-1:0]    r_tmp;
    logic [31:0]      r_word;
    t_div_req         n_req;
    t_div_rsp         w_rsp;
    logic [24:0]      n_d, n_e, n_dm;
    logic [CW-1:0]    n_lim;
    logic [12:0]      w_npost, w_npre;
    logic [24:0]      w_m, w_row_pre;

    localparam logic [1:0] PH_SHUF = 2'd1;
    localparam logic [1:0] PH_READ = 2'd2;

    wrsp_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_req), .o_rsp(w_rsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post <= CFG_W'(1024);
            r_pre  <= CFG_W'(1024);
            r_pick <= '0;
            r_half <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_POST: r_post <= i_cfg_data;
                REG_PRE:  r_pre  <= i_cfg_data;
                REG_PICK: r_pick <= i_cfg_data;
                REG_HALF: r_half <= i_cfg_data;
            endcase
        end
    end

    assign w_npost = (r_post == '0) ? 13'd1 :
                     (r_post > 13'(MAX_POSITIONS)) ? 13'(MAX_POSITIONS) : r_post;
    assign w_npre  = (r_pre > 13'(MAX_POSITIONS)) ? 13'(MAX_POSITIONS) : r_pre;
    assign w_m       = 25'(w_npre) * 25'(w_npost);
    assign w_row_pre = 25'(i_post_index) * 25'(w_npre);

    assign n_d  = (r_a >= r_b) ? r_a - r_b : r_a + r_m - r_b;
    assign n_e  = r_m - n_d;
    assign n_dm = (n_e < n_d) ? n_e : n_d;
    assign n_lim = (CW'(r_pick) < r_found) ? CW'(r_pick) : r_found;

    always_comb begin
        n_req = '0;
        if (r_state == S_IDLE && start && t_kind'(i_kind) == KIND_BEGIN) begin
            n_req.start    = 1'b1;
            n_req.dividend = 48'(w_row_pre);
            n_req.divisor  = 32'(w_m);
        end else if (r_state == S_SWDIV && r_tmp == '0) begin
            n_req.start    = 1'b1;
            n_req.dividend = {16'd0, r_word};
            n_req.divisor  = 32'(r_swp) + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m     <= w_m;
        r_npost <= w_npost;
        r_npre  <= w_npre;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_state == S_SWRD ? IW'(w_rsp.rem) :
                      (r_state == S_SWWAIT ? r_swp : r_readp[IW-1:0])];
        if (r_state == S_SCAN && r_j < r_npre && n_dm <= r_lim
            && r_found < CW'(MAX_POSITIONS)) begin
            r_mem[r_found[IW-1:0]] <= IW'(r_j);
        end else if (r_state == S_SWWR) begin
            r_mem[r_ridx] <= r_rd;
        end else if (r_state == S_SWPUT) begin
            r_mem[r_swp] <= r_tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'(PH_IDLE);
            r_found <= '0;
            r_readp <= '0;
            r_swp   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            o_pre_index <= '0;
            o_last <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start) begin
                    o_candidate_count <= 13'(r_found);
                    priority if (t_kind'(i_kind) == KIND_BEGIN) begin
                        r_found <= '0;
                        r_j     <= '0;
                        r_b     <= '0;
                        r_lim   <= 26'(r_half) * 26'(w_npost);
                        r_state <= (w_m == '0) ? S_SCAN : S_AMOD;
                    end else if (t_kind'(i_kind) == KIND_RAND) begin
                        if (r_phase != PH_SHUF || r_swp == '0 || CW'(r_swp) >= r_found) begin
                            o_valid  <= 1'b1;
                            o_status <= ST_IGNORE;
                        end else begin
                            r_word  <= i_random_word;
                            r_tmp   <= '0;
                            r_state <= S_SWDIV;
                        end
                    end else if (t_kind'(i_kind) == KIND_READ && r_phase == PH_READ) begin
                        if (r_readp < n_lim) begin
                            r_state <= S_RDA;
                        end else begin
                            r_phase  <= 2'(PH_IDLE);
                            o_valid  <= 1'b1;
                            o_status <= ST_IGNORE;
                        end
                    end else begin
                        o_valid  <= 1'b1;
                        o_status <= ST_IGNORE;
                    end
                end
                S_AMOD: if (w_rsp.done) begin
                    r_a     <= 25'(w_rsp.rem);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_m == '0 || r_j >= r_npre) begin
                        r_readp  <= '0;
                        o_valid  <= 1'b1;
                        o_candidate_count <= 13'(r_found);
                        if (r_found > CW'(1)) begin
                            r_swp    <= IW'(r_found - CW'(1));
                            r_phase  <= PH_SHUF;
                            o_status <= ST_MORE;
                        end else begin
                            r_swp    <= '0;
                            r_phase  <= PH_READ;
                            o_status <= ST_DONE;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        if (n_dm <= r_lim && r_found < CW'(MAX_POSITIONS)) begin
                            r_found <= r_found + CW'(1);
                        end
                        r_j <= r_j + 13'd1;
                        r_b <= r_b + 25'(r_npost);
                    end
                end
                S_SWDIV: begin
                    r_tmp <= IW'(1);
                    if (w_rsp.done) begin
                        r_ridx  <= IW'(w_rsp.rem);
                        r_state <= S_SWRD;
                    end
                end
                S_SWRD: r_state <= S_SWWAIT;
                S_SWWAIT: begin
                    r_tmp   <= r_rd;
                    r_state <= S_SWWR;
                end
                S_SWWR: r_state <= S_SWPUT;
                S_SWPUT: begin
                    r_swp   <= r_swp - IW'(1);
                    o_valid <= 1'b1;
                    o_candidate_count <= 13'(r_found);
                    if (r_swp == IW'(1)) begin
                        r_phase  <= PH_READ;
                        o_status <= ST_DONE;
                    end else begin
                        o_status <= ST_MORE;
                    end
                    r_state <= S_IDLE;
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: r_state <= S_RDOUT;
                S_RDOUT: begin
                    o_valid     <= 1'b1;
                    o_pre_index <= 12'(r_rd);
                    o_status    <= ST_DONE;
                    o_candidate_count <= 13'(r_found);
                    if (r_readp + CW'(1) == n_lim) begin
                        o_last  <= 1'b1;
                        r_phase <= 2'(PH_IDLE);
                    end
                    r_readp <= r_readp + CW'(1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
endmodule

[sv/wrsp_checker.sv]
// Port-level assertions for the windowed random subset picker
`include "windowed_random_subset_picker_top_macros.svh"
module wrsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_last,
    input logic [1:0]  o_status,
    input logic [11:0] o_pre_index
);
    import wrsp_pkg::*;

    `WRSP_ASSERT_NEXT(a_word_gets_result, i_clk, i_rst_n, start && !busy, busy || o_valid)
    `WRSP_ASSERT_IMP(a_last_is_given, i_clk, i_rst_n, o_valid && o_last, o_status == ST_DONE)
    `WRSP_ASSERT_IMP(a_ignored_zero, i_clk, i_rst_n, o_valid && o_status == ST_IGNORE,
        o_pre_index == 12'd0 && !o_last)
    `WRSP_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
endmodule

bind windowed_random_subset_picker_top wrsp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_last(o_last), .o_status(o_status), .o_pre_index(o_pre_index)
);

[sim/tb_windowed_random_subset_picker_top.sv]
// Testbench for the windowed random subset picker: directed and random rows checked against a predictor
`timescale 1ns / 1ps
module tb_windowed_random_subset_picker_top;
    import wrsp_pkg::*;

    localparam int NPOS = 4096;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [12:0] count;
        logic [11:0] idx;
        logic        last;
        logic [1:0]  status;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [12:0] i_cfg_data = 13'd0;
    logic [1:0]  i_kind = 2'd0;
    logic [11:0] i_post_index = 12'd0;
    logic [31:0] i_random_word = 32'd0;
    logic        o_valid;
    logic [12:0] o_candidate_count;
    logic [11:0] o_pre_index;
    logic        o_last;
    logic [1:0]  o_status;

    windowed_random_subset_picker_top uut (.*);

    // predictor state
    logic [12:0] m_post = 13'd1024, m_pre = 13'd1024, m_pick = 13'd0, m_half = 13'd0;
    logic [11:0] m_store [NPOS];
    int unsigned m_found, m_swap, m_rdpos;
    int          m_phase;     // 0 idle, 1 shuffle, 2 read
    t_word       expected_words [$];
    int          errors;
    longint      cycles;
    int          words_seen;

    initial forever #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_word e;
            words_seen++;
            if (expected_words.size() == 0) begin
                $error("unexpected word");
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (o_candidate_count !== e.count) begin
                    $error("candidate_count exp %0d got %0d", e.count, o_candidate_count);
                    errors++;
                end
                if (o_pre_index !== e.idx) begin
                    $error("pre_index exp %0d got %0d", e.idx, o_pre_index);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
            end
        end
    end

    function automatic t_word mk(logic [11:0] idx, logic last, t_status st);
        t_word w;
        w.count = m_found[12:0];
        w.idx = idx;
        w.last = last;
        w.status = st;
        return w;
    endfunction

    function automatic t_word predict_pick(logic [1:0] kind, logic [11:0] row, logic [31:0] rw);
        longint unsigned npost, npre, m, lim, a, b, d;
        int unsigned r, pl;
        logic [11:0] tmp;
        logic last;
        if (kind == KIND_BEGIN) begin
            npost = (m_post == 0) ? 1 : (m_post > NPOS ? NPOS : m_post);
            npre = (m_pre > NPOS) ? NPOS : m_pre;
            m = npre * npost;
            lim = longint'(m_half) * npost;
            m_found = 0;
            if (m != 0) begin
                a = (longint'(row) * npre) % m;
                for (int j = 0; j < npre; j++) begin
                    b = j * npost;
                    d = (a >= b) ? a - b : a + m - b;
                    if (m - d < d) d = m - d;
                    if (d <= lim && m_found < NPOS) begin
                        m_store[m_found] = j[11:0];
                        m_found++;
                    end
                end
            end
            m_rdpos = 0;
            if (m_found > 1) begin
                m_swap = m_found - 1;
                m_phase = 1;
            end else begin
                m_swap = 0;
                m_phase = 2;
            end
            return mk(12'd0, 1'b0, m_phase == 1 ? ST_MORE : ST_DONE);
        end
        if (kind == KIND_RAND) begin
            if (m_phase != 1 || m_swap == 0 || m_swap >= m_found)
                return mk(12'd0, 1'b0, ST_IGNORE);
            r = rw % (m_swap + 1);
            tmp = m_store[m_swap];
            m_store[m_swap] = m_store[r];
            m_store[r] = tmp;
            m_swap--;
            if (m_swap == 0) begin
                m_phase = 2;
                return mk(12'd0, 1'b0, ST_DONE);
            end
            return mk(12'd0, 1'b0, ST_MORE);
        end
        if (kind == KIND_READ && m_phase == 2) begin
            pl = (m_pick < m_found) ? m_pick : m_found;
            if (m_rdpos < pl) begin
                tmp = m_store[m_rdpos];
                last = (m_rdpos + 1 == pl);
                m_rdpos++;
                if (last) m_phase = 0;
                return mk(tmp, last, ST_DONE);
            end
            m_phase = 0;
            return mk(12'd0, 1'b0, ST_IGNORE);
        end
        return mk(12'd0, 1'b0, ST_IGNORE);
    endfunction

    int burst_left;

    task automatic send_word(logic [1:0] kind, logic [11:0] row, logic [31:0] rw);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        start <= 1'b1;
        i_kind <= kind;
        i_post_index <= row;
        i_random_word <= rw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_words.push_back(predict_pick(kind, row, rw));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [12:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_POST: m_post = val;
            REG_PRE:  m_pre = val;
            REG_PICK: m_pick = val;
            default:  m_half = val;
        endcase
    endtask

    task automatic set_regs(logic [12:0] po, logic [12:0] pr, logic [12:0] pk, logic [12:0] hw);
        write_reg(REG_POST, po);
        write_reg(REG_PRE, pr);
        write_reg(REG_PICK, pk);
        write_reg(REG_HALF, hw);
    endtask

    // full row: begin, swaps, reads, with occasional noise
    task automatic run_row(logic [11:0] row, int noise);
        send_word(KIND_BEGIN, row, $urandom);
        while (m_phase == 1) begin
            if ($urandom_range(0, 99) < noise)
                send_word(KIND_READ, 12'($urandom), $urandom);
            send_word(KIND_RAND, 12'($urandom), $urandom);
        end
        for (int k = 0; k < 6 && m_phase == 2; k++)
            send_word(KIND_READ, 12'($urandom), $urandom);
        if ($urandom_range(0, 99) < noise)
            send_word(2'($urandom_range(1, 3)), 12'($urandom), $urandom);
    endtask

    task automatic test_directed();
        send_word(KIND_RAND, 12'd0, 32'hFFFF_FFFF);
        send_word(KIND_READ, 12'd0, 32'd0);
        send_word(KIND_NONE, 12'hFFF, 32'd0);
        set_regs(13'd8, 13'd8, 13'd3, 13'd2);
        send_word(KIND_BEGIN, 12'hFFF, 32'd0);
        send_word(KIND_RAND, 12'd0, 32'hFFFF_FFFF);
        send_word(KIND_RAND, 12'd0, 32'd0);
        send_word(KIND_BEGIN, 12'd3, 32'd0);
        for (int k = 0; k < 4; k++) send_word(KIND_RAND, 12'd0, 32'h8000_0001 * k);
        for (int k = 0; k < 5; k++) send_word(KIND_READ, 12'd0, 32'd0);
        set_regs(13'd0, 13'd0, 13'd4096, 13'd8191);
        send_word(KIND_BEGIN, 12'd5, 32'd0);
        send_word(KIND_READ, 12'd0, 32'd0);
        set_regs(13'd8191, 13'd3, 13'd0, 13'd0);
        send_word(KIND_BEGIN, 12'd1, 32'd0);
        send_word(KIND_READ, 12'd0, 32'd0);
    endtask

    task automatic test_random_rows();
        int n;
        int pick_pre;
        int next_cfg;
        n = 0;
        next_cfg = 0;
        while (n < 1300) begin
            if (n >= next_cfg) begin
                next_cfg += 150;
                pick_pre = $urandom_range(0, 9);
                if (pick_pre == 0) set_regs(13'd4096, 13'd4096, 13'd4096, 13'd4);
                else if (pick_pre == 1) set_regs(13'($urandom), 13'($urandom_range(1, 40)),
                                                 13'($urandom_range(0, 20)), 13'($urandom));
                else set_regs(13'($urandom_range(1, 64)), 13'($urandom_range(1, 32)),
                              13'($urandom_range(0, 12)), 13'($urandom_range(0, 20)));
                drain();
            end
            begin
                int before_n;
                before_n = expected_words.size() + words_seen;
                run_row(12'($urandom), 15);
                n += expected_words.size() + words_seen - before_n;
            end
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        words_seen = 0;
        burst_left = 0;
        m_phase = 0;
        m_found = 0;
        m_swap = 0;
        m_rdpos = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_rows();
        drain();
        $display("Covered %0d checked words over directed rows and random window settings,",
                 words_seen);
        $display("including full-size rings, empty windows and out-of-sequence words.");
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/wrsp_pkg.sv
sv/wrsp_divider.sv
sv/windowed_random_subset_picker_top.sv
sv/wrsp_checker.sv
sim/tb_windowed_random_subset_picker_top.sv
